// ===== design/bra_pkg.sv =====
//==============================================================================
// bra_pkg: shared definitions for the bitmap range allocator
// Field widths, request kinds, status codes and bit-scan helpers.
//==============================================================================
`default_nettype none

package bra_pkg;

    localparam int WORD_BITS    = 32;
    localparam int WORD_SHIFT   = 5;
    localparam int MAP_BITS_DEF = 4096;

    localparam int KIND_W  = 2;
    localparam int INDEX_W = 12;
    localparam int RUN_W   = 13;
    localparam int CFG_W   = 13;
    localparam int STAT_W  = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TEST  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIND  = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    // number of ones at the low end of a word (0..32)
    function automatic logic [5:0] ones_trailing(input logic [WORD_BITS-1:0] v);
        logic [5:0] n;
        n = 6'd32;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!v[i])
            begin
                n = 6'(i);
            end
        end
        return n;
    endfunction

    // number of ones at the high end of a word (0..32)
    function automatic logic [5:0] ones_leading(input logic [WORD_BITS-1:0] v);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (!v[i])
            begin
                n = 6'(WORD_BITS - 1 - i);
            end
        end
        return n;
    endfunction

    // position of the lowest set bit (0 when none)
    function automatic logic [4:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                n = 5'(i);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== design/bra_req_if.sv =====
//==============================================================================
// bra_req_if: request channel
// Valid/ready channel carrying one allocator request.
//==============================================================================
`default_nettype none

interface bra_req_if;
    logic                            valid;
    logic                            ready;
    logic [bra_pkg::KIND_W-1:0]      kind;
    logic [bra_pkg::INDEX_W-1:0]     first_index;
    logic [bra_pkg::INDEX_W-1:0]     last_index;
    logic                            bit_value;
    logic [bra_pkg::RUN_W-1:0]       run_length;

    modport source (output valid, kind, first_index, last_index, bit_value, run_length,
                    input ready);
    modport sink   (input valid, kind, first_index, last_index, bit_value, run_length,
                    output ready);
endinterface

`default_nettype wire

// ===== design/bra_rsp_if.sv =====
//==============================================================================
// bra_rsp_if: response channel
// Valid/ready channel carrying one allocator response.
//==============================================================================
`default_nettype none

interface bra_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [bra_pkg::STAT_W-1:0]      status;
    logic [bra_pkg::INDEX_W-1:0]     result_value;

    modport source (output valid, status, result_value, input ready);
    modport sink   (input valid, status, result_value, output ready);
endinterface

`default_nettype wire

// ===== design/bra_ram.sv =====
//==============================================================================
// bra_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
//==============================================================================
`default_nettype none

module bra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/bitmap_range_allocator.sv =====
//==============================================================================
// bitmap_range_allocator: first-fit allocation bitmap
// Range write, bit test and first-fit run search over a word-wide bitmap RAM.
//==============================================================================
//
//  channel   dir  handshake        payload
//  -------   ---  ---------        -------
//  req       in   valid/ready      kind, first_index, last_index, bit_value, run_length
//  rsp       out  valid/ready      status, result_value
//  cfg       in   cfg_we           cfg_wdata -> bits_in_use
//
//  After reset a clearing pass zeroes the bitmap word by word; req.ready stays low.
//  Test reads one word. Range write and run search walk the spanned words, one word per
//  cycle through the single RAM read port; a search stops at the word that completes it.
//  Range errors, empty ranges, zero run lengths and undefined kinds skip the walk.
//  One transaction at a time: req.ready is high only while no response is pending.
//
`default_nettype none

module bitmap_range_allocator #(
    parameter int MAP_BITS = bra_pkg::MAP_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    bra_req_if.sink                          req,
    bra_rsp_if.source                        rsp,
    input  wire logic                        cfg_we,
    input  wire logic [bra_pkg::CFG_W-1:0]   cfg_wdata
);

    localparam int WB    = bra_pkg::WORD_BITS;
    localparam int WORDS = (MAP_BITS + WB - 1) / WB;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LW    = $clog2(MAP_BITS + 1);
    localparam int CW    = (LW > bra_pkg::CFG_W) ? LW : bra_pkg::CFG_W;
    localparam int IW    = bra_pkg::INDEX_W;
    localparam int RW    = bra_pkg::RUN_W;
    localparam int SH    = bra_pkg::WORD_SHIFT;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic [AW-1:0]                   clr_ptr_reg, clr_ptr_next;
    logic [bra_pkg::CFG_W-1:0]       bits_in_use_reg;
    logic [bra_pkg::KIND_W-1:0]      kind_reg, kind_next;
    logic [IW-1:0]                   first_reg, first_next;
    logic [IW-1:0]                   last_reg, last_next;
    logic                            val_reg, val_next;
    logic [RW-1:0]                   run_reg, run_next;
    logic [AW-1:0]                   issue_ptr_reg, issue_ptr_next;
    logic                            issuing_reg, issuing_next;
    logic                            pv_reg, pv_next;
    logic [AW-1:0]                   pw_reg, pw_next;
    logic [RW-1:0]                   carry_reg, carry_next;
    logic [IW-1:0]                   start_reg, start_next;
    bra_pkg::status_t                status_reg, status_next;
    logic [IW-1:0]                   result_reg, result_next;

    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [WB-1:0]                   ram_wdata;
    logic                            ram_re;
    logic [AW-1:0]                   ram_raddr;
    logic [WB-1:0]                   ram_rdata;

    bra_ram #(
        .WIDTH (WB),
        .DEPTH (WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // length in use, saturated to the map size
    logic [CW-1:0] len_sat;
    logic          in_first_err, in_last_err;

    assign len_sat = (CW'(bits_in_use_reg) > CW'(MAP_BITS)) ? CW'(MAP_BITS)
                                                            : CW'(bits_in_use_reg);
    assign in_first_err = CW'(req.first_index) >= len_sat;
    assign in_last_err  = CW'(req.last_index) >= len_sat;

    // word addresses of the latched range
    logic [AW-1:0] first_word, last_word, walk_last;
    assign first_word = AW'(first_reg[IW-1:SH]);
    assign last_word  = AW'(last_reg[IW-1:SH]);
    assign walk_last  = (kind_reg == bra_pkg::KIND_TEST) ? first_word : last_word;

    // in-range bit mask of the word being processed
    logic [SH-1:0] lo_bit, hi_bit;
    logic [WB-1:0] word_mask;
    assign lo_bit    = (pw_reg == first_word) ? first_reg[SH-1:0] : '0;
    assign hi_bit    = (pw_reg == last_word) ? last_reg[SH-1:0] : '1;
    assign word_mask = ({WB{1'b1}} << lo_bit) & ({WB{1'b1}} >> (SH'(WB - 1) - hi_bit));

    // run search on one word
    logic [WB-1:0]  match;
    logic [WB-1:0]  win [5];
    logic [WB-1:0]  win_hit;
    logic [5:0]     t_ones, l_ones;
    logic [RW:0]    span_sum;
    logic           span_hit, inner_hit;
    logic [IW-1:0]  base;
    logic [IW-1:0]  span_start;

    assign match = ~(ram_rdata ^ {WB{val_reg}}) & word_mask;
    assign base  = IW'({pw_reg, {SH{1'b0}}});

    always_comb
    begin
        logic [SH-1:0] off;
        // win[j][p] is the AND of match[p .. p+2^j-1]
        win[0] = match;
        for (int j = 1; j < 5; j++)
        begin
            win[j] = win[j-1] & (win[j-1] >> (1 << (j - 1)));
        end
        // combine power-of-two windows into a window of run_reg[4:0] bits
        win_hit = '1;
        for (int j = 0; j < 5; j++)
        begin
            off = run_reg[SH-1:0] & SH'((1 << j) - 1);
            if (run_reg[j])
            begin
                win_hit = win_hit & (win[j] >> off);
            end
        end
    end

    assign t_ones     = bra_pkg::ones_trailing(match);
    assign l_ones     = bra_pkg::ones_leading(match);
    assign span_sum   = (RW + 1)'(carry_reg) + (RW + 1)'(t_ones);
    assign span_hit   = span_sum >= (RW + 1)'(run_reg);
    assign inner_hit  = (run_reg[RW-1:SH] == '0) && (|win_hit);
    assign span_start = (carry_reg != '0) ? start_reg : base;

    always_comb
    begin
        state_next     = state_reg;
        clr_ptr_next   = clr_ptr_reg;
        kind_next      = kind_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        val_next       = val_reg;
        run_next       = run_reg;
        issue_ptr_next = issue_ptr_reg;
        issuing_next   = issuing_reg;
        pv_next        = 1'b0;
        pw_next        = pw_reg;
        carry_next     = carry_reg;
        start_next     = start_reg;
        status_next    = status_reg;
        result_next    = result_reg;

        ram_we    = 1'b0;
        ram_waddr = pw_reg;
        ram_wdata = val_reg ? (ram_rdata | word_mask) : (ram_rdata & ~word_mask);
        ram_re    = 1'b0;
        ram_raddr = issue_ptr_reg;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_ptr_reg;
                ram_wdata    = '0;
                clr_ptr_next = clr_ptr_reg + 1'b1;
                if (clr_ptr_reg == AW'(WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next      = req.kind;
                    first_next     = req.first_index;
                    last_next      = req.last_index;
                    val_next       = req.bit_value;
                    run_next       = req.run_length;
                    issue_ptr_next = AW'(req.first_index[IW-1:SH]);
                    issuing_next   = 1'b1;
                    carry_next     = '0;
                    start_next     = '0;
                    result_next    = '0;
                    status_next    = bra_pkg::ST_OK;
                    state_next     = S_DONE;
                    case (req.kind)
                        bra_pkg::KIND_WRITE:
                        begin
                            if (in_first_err || in_last_err)
                            begin
                                status_next = bra_pkg::ST_RANGE;
                            end
                            else if (req.first_index <= req.last_index)
                            begin
                                state_next = S_WALK;
                            end
                        end
                        bra_pkg::KIND_TEST:
                        begin
                            if (in_first_err)
                            begin
                                status_next = bra_pkg::ST_RANGE;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        bra_pkg::KIND_FIND:
                        begin
                            if (in_first_err || in_last_err)
                            begin
                                status_next = bra_pkg::ST_RANGE;
                            end
                            else if (req.first_index > req.last_index ||
                                     req.run_length == '0)
                            begin
                                status_next = bra_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            status_next = bra_pkg::ST_RANGE;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                // read side: one word address per cycle
                if (issuing_reg)
                begin
                    ram_re  = 1'b1;
                    pv_next = 1'b1;
                    pw_next = issue_ptr_reg;
                    if (issue_ptr_reg == walk_last)
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        issue_ptr_next = issue_ptr_reg + 1'b1;
                    end
                end

                // process side: the word read in the previous cycle
                if (pv_reg)
                begin
                    case (kind_reg)
                        bra_pkg::KIND_WRITE:
                        begin
                            ram_we = 1'b1;
                            if (pw_reg == walk_last)
                            begin
                                status_next = bra_pkg::ST_OK;
                                state_next  = S_DONE;
                            end
                        end
                        bra_pkg::KIND_TEST:
                        begin
                            result_next = IW'(ram_rdata[first_reg[SH-1:0]]);
                            status_next = bra_pkg::ST_OK;
                            state_next  = S_DONE;
                        end
                        bra_pkg::KIND_FIND:
                        begin
                            if (span_hit)
                            begin
                                result_next = span_start;
                                status_next = bra_pkg::ST_OK;
                                state_next  = S_DONE;
                            end
                            else if (inner_hit)
                            begin
                                result_next = base + IW'(bra_pkg::lowest_set(win_hit));
                                status_next = bra_pkg::ST_OK;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                if (&match)
                                begin
                                    carry_next = carry_reg + RW'(WB);
                                    start_next = span_start;
                                end
                                else
                                begin
                                    // run continues only from the top end of the word
                                    carry_next = RW'(l_ones);
                                    start_next = base + IW'(7'(WB) - 7'(l_ones));
                                end
                                if (pw_reg == walk_last)
                                begin
                                    status_next = bra_pkg::ST_NOT_FOUND;
                                    state_next  = S_DONE;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = bra_pkg::ST_RANGE;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end

            S_DONE:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_ptr_reg     <= '0;
            bits_in_use_reg <= bra_pkg::CFG_RESET;
            issuing_reg     <= 1'b0;
            pv_reg          <= 1'b0;
            status_reg      <= bra_pkg::ST_OK;
            result_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_ptr_reg <= clr_ptr_next;
            issuing_reg <= issuing_next;
            pv_reg      <= pv_next;
            status_reg  <= status_next;
            result_reg  <= result_next;
            if (cfg_we)
            begin
                bits_in_use_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        first_reg     <= first_next;
        last_reg      <= last_next;
        val_reg       <= val_next;
        run_reg       <= run_next;
        issue_ptr_reg <= issue_ptr_next;
        pw_reg        <= pw_next;
        carry_reg     <= carry_next;
        start_reg     <= start_next;
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = (state_reg == S_DONE);
    assign rsp.status       = status_reg;
    assign rsp.result_value = result_reg;

endmodule

`default_nettype wire

// ===== design/bra_chk.sv =====
//==============================================================================
// bra_chk: port-level checks for the bitmap range allocator
// Response handshake and sequencing rules, bound to the top level.
//==============================================================================
`default_nettype none

module bra_chk (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_ready,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [bra_pkg::STAT_W-1:0]    status,
    input wire logic [bra_pkg::INDEX_W-1:0]   result_value
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(status) && $stable(result_value))
        else $error("response payload changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("request taken while a response is pending");

    a_rsp_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready |=> !rsp_valid)
        else $error("second response without a request");

    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != bra_pkg::ST_OK |-> result_value == '0)
        else $error("nonzero result on failed transaction");

endmodule

bind bitmap_range_allocator bra_chk u_bra_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .status       (rsp.status),
    .result_value (rsp.result_value)
);

`default_nettype wire

// ===== tb/tb_bitmap_range_allocator.sv =====
`timescale 1ns / 1ps
//==============================================================================
// tb_bitmap_range_allocator: self-checking testbench for the allocation bitmap
// A directed table of requests, then random requests under several settings of
// bits_in_use. Each response is compared against the table's answer if given, else
// a behavioral bitmap model, with random idling on the request and response channels.
//==============================================================================

module tb_bitmap_range_allocator;

    localparam int MAP_BITS = bra_pkg::MAP_BITS_DEF;

    localparam logic [bra_pkg::KIND_W-1:0] KIND_UNDEFINED = 2'd3;

    localparam int          ITEMS_PER_PHASE  = 116;
    localparam int          SETTLE_CYCLES    = 4;
    localparam int          TAIL_CYCLES      = 150;
    localparam int unsigned LONG_HOLD_AT     = 300;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    // several times the worst-case run time of all transactions
    localparam longint unsigned RUN_LIMIT_NS = 30_000_000;

    typedef struct packed {
        logic [bra_pkg::KIND_W-1:0]  kind;
        logic [bra_pkg::INDEX_W-1:0] first_index;
        logic [bra_pkg::INDEX_W-1:0] last_index;
        logic                        bit_value;
        logic [bra_pkg::RUN_W-1:0]   run_length;
    } request_t;

    typedef struct packed {
        bra_pkg::status_t            status;
        logic [bra_pkg::INDEX_W-1:0] result_value;
    } answer_t;

    typedef struct packed {
        request_t req;
        bit       answer_given;
        answer_t  answer;
    } row_t;

    localparam int DIRECTED_COUNT = 24;

    // bitmap is all zeros and bits_in_use is at its reset value here
    localparam row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{'{bra_pkg::KIND_TEST, 12'd0, 12'd0, 1'b0, 13'd0},
          1'b1, '{bra_pkg::ST_OK, 12'd0}},
        '{'{bra_pkg::KIND_TEST, 12'd4095, 12'd0, 1'b1, 13'd0},
          1'b1, '{bra_pkg::ST_OK, 12'd0}},
        '{'{bra_pkg::KIND_FIND, 12'd0, 12'd4095, 1'b0, 13'd1},
          1'b1, '{bra_pkg::ST_OK, 12'd0}},
        '{'{bra_pkg::KIND_FIND, 12'd0, 12'd4095, 1'b1, 13'd1},
          1'b1, '{bra_pkg::ST_NOT_FOUND, 12'd0}},
        '{'{bra_pkg::KIND_FIND, 12'd0, 12'd4095, 1'b0, 13'd4096},
          1'b1, '{bra_pkg::ST_OK, 12'd0}},
        '{'{bra_pkg::KIND_FIND, 12'd0, 12'd4095, 1'b0, 13'd0},
          1'b1, '{bra_pkg::ST_NOT_FOUND, 12'd0}},
        '{'{bra_pkg::KIND_FIND, 12'd10, 12'd5, 1'b0, 13'd1},
          1'b1, '{bra_pkg::ST_NOT_FOUND, 12'd0}},
        '{'{KIND_UNDEFINED, 12'd4095, 12'd4095, 1'b1, 13'd8191},
          1'b1, '{bra_pkg::ST_RANGE, 12'd0}},
        '{'{bra_pkg::KIND_WRITE, 12'd0, 12'd4095, 1'b1, 13'd0},
          1'b1, '{bra_pkg::ST_OK, 12'd0}},
        '{'{bra_pkg::KIND_TEST, 12'd4095, 12'd4095, 1'b0, 13'd0},
          1'b1, '{bra_pkg::ST_OK, 12'd1}},
        '{'{bra_pkg::KIND_FIND, 12'd0, 12'd4095, 1'b1, 13'd4096},
          1'b1, '{bra_pkg::ST_OK, 12'd0}},
        '{'{bra_pkg::KIND_WRITE, 12'd100, 12'd100, 1'b0, 13'd0},
          1'b1, '{bra_pkg::ST_OK, 12'd0}},
        '{'{bra_pkg::KIND_FIND, 12'd0, 12'd4095, 1'b0, 13'd1},
          1'b1, '{bra_pkg::ST_OK, 12'd100}},
        '{'{bra_pkg::KIND_WRITE, 12'd200, 12'd263, 1'b0, 13'd7},
          1'b0, '{bra_pkg::ST_OK, 12'd0}},
        '{'{bra_pkg::KIND_FIND, 12'd0, 12'd4095, 1'b0, 13'd2},
          1'b0, '{bra_pkg::ST_OK, 12'd0}},
        '{'{bra_pkg::KIND_FIND, 12'd0, 12'd4095, 1'b0, 13'd65},
          1'b0, '{bra_pkg::ST_OK, 12'd0}},
        '{'{bra_pkg::KIND_FIND, 12'd0, 12'd4095, 1'b1, 13'd8191},
          1'b1, '{bra_pkg::ST_NOT_FOUND, 12'd0}},
        '{'{bra_pkg::KIND_WRITE, 12'd500, 12'd499, 1'b0, 13'd0},
          1'b1, '{bra_pkg::ST_OK, 12'd0}},
        '{'{bra_pkg::KIND_TEST, 12'd500, 12'd0, 1'b0, 13'd0},
          1'b0, '{bra_pkg::ST_OK, 12'd0}},
        '{'{bra_pkg::KIND_WRITE, 12'd100, 12'd100, 1'b1, 13'd0},
          1'b0, '{bra_pkg::ST_OK, 12'd0}},
        '{'{bra_pkg::KIND_FIND, 12'd4095, 12'd4095, 1'b1, 13'd1},
          1'b0, '{bra_pkg::ST_OK, 12'd0}},
        '{'{bra_pkg::KIND_FIND, 12'd31, 12'd32, 1'b1, 13'd2},
          1'b0, '{bra_pkg::ST_OK, 12'd0}},
        '{'{bra_pkg::KIND_WRITE, 12'd0, 12'd4095, 1'b0, 13'd0},
          1'b1, '{bra_pkg::ST_OK, 12'd0}},
        '{'{bra_pkg::KIND_TEST, 12'd2048, 12'd0, 1'b1, 13'd0},
          1'b0, '{bra_pkg::ST_OK, 12'd0}}
    };

    localparam int PHASE_COUNT = 8;
    localparam logic [bra_pkg::CFG_W-1:0] BITS_SETTINGS [PHASE_COUNT] = '{
        13'd0, 13'd32, 13'd8191, 13'd100, 13'd4064, 13'd4095, 13'd1024, 13'd4096
    };

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_we;
    logic [bra_pkg::CFG_W-1:0]   cfg_wdata;

    bra_req_if req_ch ();
    bra_rsp_if rsp_ch ();

    bitmap_range_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    logic [MAP_BITS-1:0]         map_model;
    logic [bra_pkg::CFG_W-1:0]   bits_in_use_model;
    answer_t                     pending_answers [$];
    int unsigned                 answers_seen;
    int unsigned                 error_count;
    bit                          idle_on;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned p;
        p = $urandom_range(99, 0);
        if (p < 60)
            return 0;
        if (p < 93)
            return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // first-fit model: updates map_model for range writes
    function automatic answer_t predict_answer(request_t r);
        answer_t     a;
        int unsigned len;
        int unsigned lo;
        int unsigned hi;
        int unsigned start;
        int unsigned count;
        bit          found;
        len   = (bits_in_use_model > MAP_BITS) ? MAP_BITS : bits_in_use_model;
        lo    = r.first_index;
        hi    = r.last_index;
        start = 0;
        count = 0;
        found = 1'b0;
        a.status       = bra_pkg::ST_OK;
        a.result_value = '0;
        case (r.kind)
            bra_pkg::KIND_WRITE:
            begin
                if (lo >= len || hi >= len)
                    a.status = bra_pkg::ST_RANGE;
                else
                    for (int i = lo; i <= hi; i++)
                        map_model[i] = r.bit_value;
            end
            bra_pkg::KIND_TEST:
            begin
                if (lo >= len)
                    a.status = bra_pkg::ST_RANGE;
                else
                    a.result_value = bra_pkg::INDEX_W'(map_model[lo]);
            end
            bra_pkg::KIND_FIND:
            begin
                if (lo >= len || hi >= len)
                    a.status = bra_pkg::ST_RANGE;
                else
                begin
                    if (r.run_length != 0)
                    begin
                        for (int i = lo; i <= hi && !found; i++)
                        begin
                            if (map_model[i] == r.bit_value)
                            begin
                                if (count == 0)
                                    start = i;
                                count++;
                                if (count == r.run_length)
                                    found = 1'b1;
                            end
                            else
                                count = 0;
                        end
                    end
                    if (found)
                        a.result_value = bra_pkg::INDEX_W'(start);
                    else
                        a.status = bra_pkg::ST_NOT_FOUND;
                end
            end
            default:
                a.status = bra_pkg::ST_RANGE;
        endcase
        return a;
    endfunction

    // mostly in-range requests with short spans; some noise over the whole index space
    function automatic request_t random_request(int unsigned len);
        request_t    r;
        int unsigned pick;
        int unsigned top;
        int unsigned span;
        int unsigned lo;
        pick = $urandom_range(99, 0);
        if (pick < 35)
            r.kind = bra_pkg::KIND_WRITE;
        else if (pick < 60)
            r.kind = bra_pkg::KIND_TEST;
        else if (pick < 97)
            r.kind = bra_pkg::KIND_FIND;
        else
            r.kind = KIND_UNDEFINED;
        r.bit_value = 1'($urandom_range(1, 0));
        top = (len == 0) ? 0 : len - 1;
        if (len == 0 || $urandom_range(9, 0) == 0)
        begin
            r.first_index = bra_pkg::INDEX_W'($urandom);
            r.last_index  = bra_pkg::INDEX_W'($urandom);
        end
        else
        begin
            lo = $urandom_range(top, 0);
            if ($urandom_range(3, 0) == 0)
                span = $urandom_range(top, 0);
            else
                span = $urandom_range(40, 0);
            r.first_index = bra_pkg::INDEX_W'(lo);
            if ($urandom_range(19, 0) == 0)
                r.last_index = bra_pkg::INDEX_W'($urandom_range(lo, 0));
            else
                r.last_index = bra_pkg::INDEX_W'((lo + span > top) ? top : lo + span);
        end
        pick = $urandom_range(99, 0);
        if (pick < 70)
            r.run_length = bra_pkg::RUN_W'($urandom_range(6, 1));
        else if (pick < 90)
            r.run_length = bra_pkg::RUN_W'($urandom_range(40, 1));
        else if (pick < 95)
            r.run_length = '0;
        else
            r.run_length = bra_pkg::RUN_W'($urandom);
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after the request is taken
    task automatic drive_request(request_t r, bit answer_given, answer_t given);
        int unsigned gap;
        answer_t     predicted;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= r.kind;
        req_ch.first_index <= r.first_index;
        req_ch.last_index  <= r.last_index;
        req_ch.bit_value   <= r.bit_value;
        req_ch.run_length  <= r.run_length;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = predict_answer(r);
        pending_answers.push_back(answer_given ? given : predicted);
        @(negedge clk);
    endtask

    task automatic quiesce();
        req_ch.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned len;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.kind        <= bra_pkg::KIND_WRITE;
        req_ch.first_index <= '0;
        req_ch.last_index  <= '0;
        req_ch.bit_value   <= 1'b0;
        req_ch.run_length  <= '0;
        map_model          = '0;
        bits_in_use_model  = bra_pkg::CFG_RESET;
        idle_on            = 1'b1;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int k = 0; k < DIRECTED_COUNT; k++)
            drive_request(DIRECTED_ROWS[k].req, DIRECTED_ROWS[k].answer_given,
                          DIRECTED_ROWS[k].answer);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            quiesce();
            repeat (SETTLE_CYCLES) @(negedge clk);
            idle_on = (p != 4);
            cfg_we            <= 1'b1;
            cfg_wdata         <= BITS_SETTINGS[p];
            bits_in_use_model = BITS_SETTINGS[p];
            @(negedge clk);
            cfg_we <= 1'b0;
            len = (BITS_SETTINGS[p] > MAP_BITS) ? MAP_BITS : BITS_SETTINGS[p];
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // sender pause: let every outstanding transaction drain
                if (n == ITEMS_PER_PHASE / 2)
                    quiesce();
                drive_request(random_request(len), 1'b0, '0);
            end
        end

        quiesce();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : answer_sink
        int unsigned stall;
        bit          long_hold_done;
        long_hold_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            // one long hold-off so the block backs up onto the request channel
            if (!long_hold_done && answers_seen >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                stall = LONG_HOLD_CYCLES;
            end
            else
                stall = idle_on ? pick_gap() : 0;
            if (stall == 0)
            begin
                rsp_ch.ready <= 1'b1;
                @(negedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_answers
        answer_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            answers_seen++;
            if (pending_answers.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected transaction: status %0d result %0d", $time,
                         rsp_ch.status, rsp_ch.result_value);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    error_count++;
                    $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                             want.status, rsp_ch.status);
                end
                if (rsp_ch.result_value !== want.result_value)
                begin
                    error_count++;
                    $display("%0t: result_value mismatch: expected %0d, actual %0d", $time,
                             want.result_value, rsp_ch.result_value);
                end
            end
        end
    end

    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("%0t: timeout, %0d transactions still pending", $time,
                 pending_answers.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== bitmap_range_allocator.f =====
design/bra_pkg.sv
design/bra_req_if.sv
design/bra_rsp_if.sv
design/bra_ram.sv
design/bitmap_range_allocator.sv
design/bra_chk.sv
tb/tb_bitmap_range_allocator.sv
